/* src/pam3_scrambler_3b2t_mapper_core_assert.svh */
// Assertion macros for the 3B2T PAM3 scrambler/mapper core.
// Included by the top level; depends on nothing else.
`ifndef PAM3_SCRAMBLER_3B2T_MAPPER_CORE_ASSERT_SVH
`define PAM3_SCRAMBLER_3B2T_MAPPER_CORE_ASSERT_SVH

// same-cycle implication
`define P3S_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("p3s assertion failed");

// next-cycle implication
`define P3S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("p3s assertion failed");

`endif

/* src/p3s_pkg.sv */
// Shared types, register indexes and symbol tables for the 3B2T scrambler/mapper.
// No dependencies.
package p3s_pkg;

   localparam int unsigned SeedW   = 33;
   localparam int unsigned CsrIdxW = 2;
   localparam int unsigned CodeW   = 2;

   localparam logic [SeedW-1:0] SEED_RESET = 33'd353095693;

   localparam logic [CsrIdxW-1:0] REG_MODE = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_SEED = 2'd1;

   typedef enum logic [1:0] {
      MODE_ZERO    = 2'd0,
      MODE_DATA    = 2'd1,
      MODE_ALT     = 2'd2,
      MODE_ZERO_HI = 2'd3
   } mode_type;

   // scrambling bits taken from the stepped scrambler state
   typedef struct packed {
      logic [2:0] sy;
      logic       sx;
   } scr_bits_type;

   // symbol A in [3:2], symbol B in [1:0]
   localparam logic [3:0] MAP_MAIN [8] = '{
      4'h4, 4'h3, 4'h7, 4'h3, 4'hC, 4'h1, 4'hD, 4'h1
   };
   localparam logic [3:0] MAP_ALT [8] = '{
      4'h4, 4'hF, 4'h7, 4'hF, 4'hC, 4'h5, 4'hD, 4'h5
   };

endpackage

/* src/p3s_scrambler.sv */
// Side-stream scrambler, x^33 + x^13 + 1, one step per accepted beat.
// Depends on p3s_pkg.
module p3s_scrambler
   import p3s_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               seed_load,
   input  logic [SeedW-1:0]   seed_value,
   input  logic               step,
   output scr_bits_type       scr_bits
);

   logic [SeedW-1:0] state_ff;
   logic [SeedW-1:0] state_in;
   logic [SeedW-1:0] stepped;

   assign stepped = {state_ff[SeedW-2:0], state_ff[32] ^ state_ff[12]};

   always_comb begin
      state_in = state_ff;
      if (seed_load) begin
         state_in = seed_value;
      end else if (step) begin
         state_in = stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEED_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // bits come from the state after this beat's step
   assign scr_bits.sy[0] = stepped[0];
   assign scr_bits.sy[1] = stepped[3] ^ stepped[8];
   assign scr_bits.sy[2] = stepped[6] ^ stepped[16];
   assign scr_bits.sx    = stepped[7] ^ stepped[9] ^ stepped[12] ^ stepped[14];

endmodule

/* src/p3s_mapper.sv */
// 3-bit data group, scrambled with the sy bits, to TA/TB ternary codes, per mode.
// Depends on p3s_pkg.
module p3s_mapper
   import p3s_pkg::*;
(
   input  mode_type           mode,
   input  logic [2:0]         data,
   input  scr_bits_type       scr_bits,
   output logic [CodeW-1:0]   symbol_a,
   output logic [CodeW-1:0]   symbol_b
);

   logic [2:0] sd;
   logic [3:0] code;

   assign sd = data ^ scr_bits.sy;

   always_comb begin
      case (mode)
         MODE_DATA: code = MAP_MAIN[sd];
         MODE_ALT:  code = scr_bits.sx ? MAP_ALT[sd] : MAP_MAIN[sd];
         default:   code = 4'h0;
      endcase
   end

   assign symbol_a = code[3:2];
   assign symbol_b = code[1:0];

endmodule

/* src/pam3_scrambler_3b2t_mapper_core.sv */
// Top level of the 3B2T PAM3 scrambler/mapper: beat pipeline and CSRs.
// Depends on p3s_pkg, p3s_scrambler, p3s_mapper and the assertion header.
//
// Usage:
//   req channel: one beat carries three data bits (one symbol period).
//   rsp channel: one beat carries the TA/TB ternary codes for it
//     (0 zero, 1 plus one, 3 minus one).
//   Both channels use valid/stall; a beat moves when valid is high and
//   stall is low.
//   The scrambler steps and its bits are captured with the data in
//   the input register; the mapper result then lands in the output
//   register.
//   Throughput is one beat per cycle while rsp is not stalled; the
//   scrambler steps once per accepted beat, feeding the input register.
//   When rsp is stalled, the output register holds its beat and the input
//   register can still take one more; req_stall rises only when both
//   are full.
//   Reset loads the default seed into the scrambler, sets mode 0 and
//   empties both registers. CSR writes: index 0 is mode, index 1 loads
//   the seed straight into the scrambler; other indexes are ignored.
module pam3_scrambler_3b2t_mapper_core
   import p3s_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [SeedW-1:0]   csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_data_bit0,
   input  logic               req_data_bit1,
   input  logic               req_data_bit2,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CodeW-1:0]   rsp_symbol_a,
   output logic [CodeW-1:0]   rsp_symbol_b
);

`include "pam3_scrambler_3b2t_mapper_core_assert.svh"

   mode_type           mode_ff, mode_in;
   logic               in_valid_ff, in_valid_in;
   logic [2:0]         in_data_ff, in_data_in;
   scr_bits_type       in_scr_ff, in_scr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CodeW-1:0]   sym_a_ff, sym_a_in;
   logic [CodeW-1:0]   sym_b_ff, sym_b_in;

   logic               req_accept;
   logic               out_free;
   logic               in_advance;
   logic               seed_load;
   scr_bits_type       scr_bits;
   logic [CodeW-1:0]   map_a;
   logic [CodeW-1:0]   map_b;

   assign seed_load  = csr_we && (csr_index == REG_SEED);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign in_advance = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   p3s_scrambler u_scrambler (
      .clock      (clock),
      .reset      (reset),
      .seed_load  (seed_load),
      .seed_value (csr_wdata),
      .step       (req_accept),
      .scr_bits   (scr_bits)
   );

   p3s_mapper u_mapper (
      .mode     (mode_ff),
      .data     (in_data_ff),
      .scr_bits (in_scr_ff),
      .symbol_a (map_a),
      .symbol_b (map_b)
   );

   always_comb begin
      mode_in = mode_ff;
      if (csr_we && (csr_index == REG_MODE)) begin
         mode_in = mode_type'(csr_wdata[1:0]);
      end

      in_valid_in = req_accept || (in_valid_ff && !in_advance);
      in_data_in  = in_data_ff;
      in_scr_in   = in_scr_ff;
      if (req_accept) begin
         in_data_in = {req_data_bit2, req_data_bit1, req_data_bit0};
         in_scr_in  = scr_bits;
      end

      rsp_valid_in = in_advance || (rsp_valid_ff && rsp_stall);
      sym_a_in     = sym_a_ff;
      sym_b_in     = sym_b_ff;
      if (in_advance) begin
         sym_a_in = map_a;
         sym_b_in = map_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ZERO;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_data_ff <= in_data_in;
      in_scr_ff  <= in_scr_in;
      sym_a_ff   <= sym_a_in;
      sym_b_ff   <= sym_b_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_symbol_a = sym_a_ff;
   assign rsp_symbol_b = sym_b_ff;

   // code 2 never comes out of either table
   `P3S_ASSERT_IMPL(a_no_bad_code, clock, reset, rsp_valid_ff,
      (sym_a_ff != 2'd2) && (sym_b_ff != 2'd2))
   // a blocked input beat stays put
   `P3S_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !out_free,
      in_valid_ff && (in_data_ff == $past(in_data_ff)))
   // a beat leaving the input register always lands in the output register
   `P3S_ASSERT_NEXT(a_in_to_out, clock, reset, in_advance, rsp_valid_ff)

endmodule

/* dv/pam3_scrambler_3b2t_mapper_core_checker.sv */
// Scoreboard for the 3B2T PAM3 scrambler/mapper: tracks CSR writes and accepted req beats,
// predicts each TA/TB pair and compares it with the rsp beats in order.
// Depends on p3s_pkg for widths, register indexes and the mode enum.
module pam3_scrambler_3b2t_mapper_core_checker
   import p3s_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [SeedW-1:0]   csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_data_bit0,
   input  logic               req_data_bit1,
   input  logic               req_data_bit2,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [CodeW-1:0]   rsp_symbol_a,
   input  logic [CodeW-1:0]   rsp_symbol_b,
   output int                 fail_count,
   output int                 pending_count,
   output int                 results_checked,
   output int                 alt_hits
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [SeedW-1:0] POWER_ON_SEED = 33'd353095693;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [CodeW-1:0] sym_a;
      logic [CodeW-1:0] sym_b;
   } symbol_pair_type;

   // TA in [3:2], TB in [1:0]; codes 0 zero, 1 plus one, 3 minus one
   localparam logic [3:0] PAIR_MAIN [8] = '{
      4'h4, 4'h3, 4'h7, 4'h3, 4'hC, 4'h1, 4'hD, 4'h1
   };
   localparam logic [3:0] PAIR_ALT [8] = '{
      4'h4, 4'hF, 4'h7, 4'hF, 4'hC, 4'h5, 4'hD, 4'h5
   };

   symbol_pair_type  expected_pairs[$];
   logic [SeedW-1:0] scr_state = POWER_ON_SEED;
   mode_type         cur_mode  = MODE_ZERO;
   int               mismatches = 0;
   int               checked    = 0;
   int               alt_count  = 0;

   // map one data group against the already stepped scrambler state
   function automatic symbol_pair_type map_group(input mode_type m, input logic [SeedW-1:0] s,
                                                 input logic [2:0] data, output bit took_alt);
      logic [2:0] sy;
      logic       sx;
      logic [2:0] sd;
      logic [3:0] pair;
      sy = {s[6] ^ s[16], s[3] ^ s[8], s[0]};
      sx = s[7] ^ s[9] ^ s[12] ^ s[14];
      sd = data ^ sy;
      took_alt = 1'b0;
      case (m)
         MODE_DATA: pair = PAIR_MAIN[sd];
         MODE_ALT: begin
            took_alt = sx;
            pair = sx ? PAIR_ALT[sd] : PAIR_MAIN[sd];
         end
         default: pair = 4'h0;
      endcase
      return symbol_pair_type'(pair);
   endfunction

   always @(posedge clock) begin : watch_beats
      symbol_pair_type want;
      symbol_pair_type got;
      bit              took_alt;
      if (reset) begin
         scr_state = POWER_ON_SEED;
         cur_mode  = MODE_ZERO;
         expected_pairs.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.sym_a = rsp_symbol_a;
            got.sym_b = rsp_symbol_b;
            if (expected_pairs.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: rsp beat with nothing expected: a=%0d b=%0d",
                           $realtime, got.sym_a, got.sym_b);
            end else begin
               want = expected_pairs.pop_front();
               checked++;
               if (got.sym_a !== want.sym_a || got.sym_b !== want.sym_b) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("%0t: rsp beat %0d mismatch: expected a=%0d b=%0d, got a=%0d b=%0d",
                              $realtime, checked, want.sym_a, want.sym_b,
                              got.sym_a, got.sym_b);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_MODE: cur_mode  = mode_type'(csr_wdata[1:0]);
               REG_SEED: scr_state = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            // x^33 + x^13 + 1, one step per beat in every mode
            scr_state = {scr_state[SeedW-2:0], scr_state[32] ^ scr_state[12]};
            want = map_group(cur_mode, scr_state,
                             {req_data_bit2, req_data_bit1, req_data_bit0}, took_alt);
            if (took_alt)
               alt_count++;
            expected_pairs.push_back(want);
         end
      end
      fail_count      <= mismatches;
      pending_count   <= expected_pairs.size();
      results_checked <= checked;
      alt_hits        <= alt_count;
   end

endmodule

/* dv/pam3_scrambler_3b2t_mapper_core_tb.sv */
// Top of the 3B2T PAM3 scrambler/mapper bench: clock, reset, CSR setup, req stimulus
// and rsp stalls. Checking lives in pam3_scrambler_3b2t_mapper_core_checker.
// Depends on p3s_pkg, the core and the checker.
module pam3_scrambler_3b2t_mapper_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import p3s_pkg::*;

   localparam int IDLE_PCT       = 19;
   localparam int RANDOM_BEATS   = 1000;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int STEADY_PHASE   = 3;
   localparam int PAUSE_PHASE    = 2;

   // indexes the core must ignore
   localparam logic [CsrIdxW-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CsrIdxW-1:0] REG_SPARE_B = 2'd3;
   localparam logic [SeedW-1:0]   SEED_ZERO   = '0;
   localparam logic [SeedW-1:0]   SEED_ONES   = '1;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               csr_we        = 1'b0;
   logic [CsrIdxW-1:0] csr_index     = '0;
   logic [SeedW-1:0]   csr_wdata     = '0;
   logic               req_valid     = 1'b0;
   logic               req_data_bit0 = 1'b0;
   logic               req_data_bit1 = 1'b0;
   logic               req_data_bit2 = 1'b0;
   logic               rsp_stall     = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic [CodeW-1:0]   rsp_symbol_a;
   logic [CodeW-1:0]   rsp_symbol_b;

   bit steady        = 1'b0;
   int beats_sent    = 0;
   int settings_used = 0;
   int idle_cycles   = 0;
   int fail_count;
   int pending_count;
   int results_checked;
   int alt_hits;

   pam3_scrambler_3b2t_mapper_core dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_bit0 (req_data_bit0),
      .req_data_bit1 (req_data_bit1),
      .req_data_bit2 (req_data_bit2),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_symbol_a  (rsp_symbol_a),
      .rsp_symbol_b  (rsp_symbol_b)
   );

   pam3_scrambler_3b2t_mapper_core_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_bit0   (req_data_bit0),
      .req_data_bit1   (req_data_bit1),
      .req_data_bit2   (req_data_bit2),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol_a    (rsp_symbol_a),
      .rsp_symbol_b    (rsp_symbol_b),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .alt_hits        (alt_hits)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   // counts cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  idle_cycles, pending_count);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_group(input logic [2:0] bits);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_bit0 <= bits[0];
      req_data_bit1 <= bits[1];
      req_data_bit2 <= bits[2];
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      beats_sent++;
   endtask

   // hold off the sender until every outstanding symbol pair has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [SeedW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(input mode_type m, input bit load_seed,
                                input logic [SeedW-1:0] seed);
      logic [SeedW-1:0] word;
      // junk in the upper bits, only [1:0] should land in mode
      word      = SeedW'({$urandom, $urandom});
      word[1:0] = m;
      write_reg(REG_MODE, word);
      if (load_seed)
         write_reg(REG_SEED, seed);
      if ($urandom_range(1))
         write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                   SeedW'({$urandom, $urandom}));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic mode_type pick_mode();
      int r;
      r = $urandom_range(99);
      if (r < 10)
         return MODE_ZERO;
      else if (r < 45)
         return MODE_DATA;
      else if (r < 90)
         return MODE_ALT;
      else
         return MODE_ZERO_HI;
   endfunction

   function automatic logic [SeedW-1:0] pick_seed();
      int r;
      r = $urandom_range(7);
      if (r == 0)
         return SEED_ZERO;
      else if (r == 1)
         return SEED_ONES;
      else
         return SeedW'({$urandom, $urandom});
   endfunction

   initial begin
      int phase;
      int phase_len;
      int random_goal;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero mode straight out of reset, scrambler still stepping
      send_group(3'b000);
      send_group(3'b111);
      wait_drained();
      // zero seed keeps the scrambler at zero: plain table walk
      apply_setting(MODE_DATA, 1'b1, SEED_ZERO);
      for (int g = 0; g < 8; g++)
         send_group(g[2:0]);
      wait_drained();
      apply_setting(MODE_ALT, 1'b1, SEED_ONES);
      for (int g = 0; g < 8; g++)
         send_group(g[2:0]);
      wait_drained();
      apply_setting(MODE_ZERO_HI, 1'b0, SEED_ZERO);
      send_group(3'b111);
      send_group(3'b010);
      send_group(3'b101);
      wait_drained();
      // mode change alone must not reload the scrambler
      apply_setting(MODE_DATA, 1'b0, SEED_ZERO);
      send_group(3'b011);
      send_group(3'b100);

      phase       = 0;
      random_goal = beats_sent + RANDOM_BEATS;
      while (beats_sent < random_goal) begin
         wait_drained();
         apply_setting(pick_mode(), $urandom_range(2) != 0, pick_seed());
         steady    <= (phase == STEADY_PHASE);
         phase_len  = (phase == STEADY_PHASE) ? 200 : $urandom_range(40, 160);
         for (int i = 0; i < phase_len; i++) begin
            if (phase == PAUSE_PHASE && i == phase_len / 2)
               wait_drained();
            send_group(3'($urandom_range(7)));
         end
         phase++;
      end
      steady <= 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d beats over %0d register settings (all modes, zero/all-ones seeds)",
               beats_sent, settings_used);
      $display("compared %0d symbol pairs, %0d through the alternate table, %0d mismatches",
               results_checked, alt_hits, fail_count);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
